>>> rtl/srrc_pkg.sv
// Package for the sorted array rank counter: sizes, payload words,
// operation codes and controller states. No dependencies.
package srrc_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VAL_W       = 16;

  // operation codes carried in the input word
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [4:0]              entry_index;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [5:0] less_count;
    logic [5:0] equal_count;
    logic [5:0] greater_count;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_e;

endpackage

>>> rtl/sorted_array_rank_counter_unit.sv
// Sorted array rank counter: table memory, binary search controller and
// result register. Depends on srrc_pkg.
//
//  channel | signals                          | direction | word
//  in      | in_valid_i/in_ready_o/in_data_i  | input     | in_word_t
//  out     | out_valid_o/out_ready_i/out_data_o | output  | out_word_t
//  cfg     | cfg_we_i/cfg_wdata_i             | input     | entry_count
//
// A load word is written to the table at its acceptance edge and the block
// is ready again in the next cycle. A query is accepted, then probes the
// table for the lower bound and again for the upper bound (up to six
// probes each for 32 entries), then writes the result register. Probes use
// the registered read data of the single table read port.
// Reset (rst_ni low) returns the controller to idle and entry_count to 32;
// the table itself is not cleared. A stalled result holds in the output
// register, and a following query waits in its done state until it is taken.
module sorted_array_rank_counter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  srrc_pkg::in_word_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output srrc_pkg::out_word_t out_data_o
);
  import srrc_pkg::*;

  state_e state_q, state_d;

  logic [5:0]              entry_count_q;
  logic [CNT_W-1:0]        n_q, n_d;
  logic [CNT_W-1:0]        lo_q, lo_d;
  logic [CNT_W-1:0]        hi_q, hi_d;
  logic [CNT_W-1:0]        lb_q, lb_d;
  logic [CNT_W-1:0]        ub_q, ub_d;
  logic [IDX_W-1:0]        mid_q, mid_d;
  logic                    strict_q, strict_d;
  logic signed [VAL_W-1:0] x_q, x_d;

  logic signed [VAL_W-1:0] mem_q [TABLE_DEPTH];
  logic signed [VAL_W-1:0] rdata_q;

  logic                    out_valid_q, out_valid_d;
  out_word_t               out_data_q, out_data_d;

  logic                    in_fire, is_query, out_free;
  logic [CNT_W-1:0]        n_sat;
  logic                    go_right, last_probe;
  logic [CNT_W-1:0]        new_lo, new_hi;
  logic [CNT_W-1:0]        sum_a, sum_b;
  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        top, eq_cnt;

  // handshake decode
  assign in_fire  = in_valid_i && in_ready_o;
  assign is_query = (in_data_i.operation == OP_QUERY);
  assign out_free = !out_valid_q || out_ready_i;

  // entry count saturated to the table depth
  assign n_sat = (CNT_W'(entry_count_q) > CNT_W'(TABLE_DEPTH))
               ? CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count_q);

  // probe compare on the registered read data
  assign go_right   = strict_q ? (rdata_q <= x_q) : (rdata_q < x_q);
  assign new_lo     = go_right ? (CNT_W'(mid_q) + CNT_W'(1)) : lo_q;
  assign new_hi     = go_right ? hi_q : CNT_W'(mid_q);
  assign last_probe = !(new_lo < new_hi);

  // bounds to counts
  assign top    = (ub_q > lb_q) ? ub_q : lb_q;
  assign eq_cnt = (ub_q > lb_q) ? (ub_q - lb_q) : '0;

  // midpoint of the next search interval
  always_comb begin
    sum_a = new_lo;
    sum_b = new_hi;
    if (state_q == ST_IDLE) begin
      sum_a = '0;
      sum_b = n_sat;
    end else if (last_probe) begin
      sum_a = '0;
      sum_b = n_q;
    end
    mid_sum = {1'b0, sum_a} + {1'b0, sum_b};
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && is_query) begin
          state_d = (n_sat == '0) ? ST_DONE : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (last_probe && strict_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // controller outputs and search datapath
  always_comb begin
    in_ready_o  = 1'b0;
    n_d         = n_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    lb_d        = lb_q;
    ub_d        = ub_q;
    mid_d       = mid_q;
    strict_d    = strict_q;
    x_d         = x_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire && is_query) begin
          x_d      = in_data_i.value;
          n_d      = n_sat;
          lo_d     = '0;
          hi_d     = n_sat;
          lb_d     = '0;
          ub_d     = '0;
          strict_d = 1'b0;
          mid_d    = mid_sum[IDX_W:1];
        end
      end
      ST_PROBE: begin
        if (!last_probe) begin
          lo_d  = new_lo;
          hi_d  = new_hi;
          mid_d = mid_sum[IDX_W:1];
        end else if (!strict_q) begin
          // lower bound found, restart for the upper bound
          lb_d     = new_lo;
          strict_d = 1'b1;
          lo_d     = '0;
          hi_d     = n_q;
          mid_d    = mid_sum[IDX_W:1];
        end else begin
          ub_d = new_lo;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_data_d.less_count    = 6'(lb_q);
          out_data_d.equal_count   = 6'(eq_cnt);
          out_data_d.greater_count = 6'(n_q - top);
        end
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= 6'(TABLE_DEPTH);
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
    end
  end

  // search and result payload registers
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    lb_q       <= lb_d;
    ub_q       <= ub_d;
    mid_q      <= mid_d;
    strict_q   <= strict_d;
    x_q        <= x_d;
    out_data_q <= out_data_d;
  end

  // table memory: write on load, registered read at the next probe address
  always_ff @(posedge clk_i) begin
    if (in_fire && !is_query) begin
      mem_q[in_data_i.entry_index] <= in_data_i.value;
    end
    rdata_q <= mem_q[mid_d];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/srrc_checker.sv
// Port-level checks for the sorted array rank counter, bound to the top
// level. Depends on srrc_pkg.
module srrc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input srrc_pkg::in_word_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input srrc_pkg::out_word_t out_data_o
);
  import srrc_pkg::*;

  logic       in_fire;
  logic [6:0] count_sum;

  assign in_fire   = in_valid_i && in_ready_o;
  assign count_sum = 7'(out_data_o.less_count) + 7'(out_data_o.equal_count)
                   + 7'(out_data_o.greater_count);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // the three counts together never exceed the table depth
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_sum <= 7'(TABLE_DEPTH))
    else $error("counts exceed table depth");

  // a load completes at once and leaves the block ready
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.operation == OP_LOAD) |=> in_ready_o)
    else $error("not ready after a load word");

  // a query occupies the block for at least the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.operation == OP_QUERY) |=> !in_ready_o)
    else $error("ready right after a query word");

endmodule

bind sorted_array_rank_counter_unit srrc_checker u_srrc_checker (.*);
